// ----- rtl/aau_pkg.sv -----
// ----------------------------------------------------------------------------
// aau_pkg: shared types and constants of the annealing acceptance unit
// Holds the datapath command and status structs, the controller states and
// the fixed-point constants used by the acceptance test.
// ----------------------------------------------------------------------------
package aau_pkg;

    localparam int SCORE_W = 48;
    localparam int RAND_W  = 16;
    localparam int WORD_W  = 32;

    // Register reset values: 1000.0, about 0.99999 and about 0.01.
    localparam logic [WORD_W-1:0] START_TEMP_RST = 32'd65536000;
    localparam logic [WORD_W-1:0] COOL_RST       = 32'd4294924346;
    localparam logic [WORD_W-1:0] STOP_TEMP_RST  = 32'd655;

    // ln(2) in Q32 and 1.0 in UQ1.16.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [3:0] TAYLOR_TERMS = 4'd12;

    // Cycle counts of the iterative steps, loaded as count minus one.
    localparam logic [4:0] QDIV_LAST = 5'd19;
    localparam logic [4:0] NDIV_LAST = 5'd4;
    localparam logic [4:0] KDIV_LAST = 5'd8;

    typedef enum logic [1:0] {
        CFG_START_TEMP = 2'd0,
        CFG_COOLING    = 2'd1,
        CFG_STOP_TEMP  = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_EVAL,
        OP_QSTEP,
        OP_NSTEP,
        OP_MUL,
        OP_KDIV,
        OP_ACC,
        OP_ROUND,
        OP_COMMIT,
        OP_OUT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_QDIV,
        S_NDIV,
        S_MUL,
        S_KDIV,
        S_ACC,
        S_ROUND,
        S_COMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        t_dp_op     op;
        logic [4:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic seeded;
        logic stopped;
        logic lt_cur;
        logic diff_zero;
        logic big;
        logic k_last;
    } t_dp_status;

endpackage

// ----- rtl/aau_channels.sv -----
// ----------------------------------------------------------------------------
// aau_channels: valid/ready channels of the annealing acceptance unit
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface aau_item_if;
    logic        valid;
    logic        ready;
    logic [47:0] candidate_score;
    logic [15:0] random_fraction;

    modport source (output valid, candidate_score, random_fraction, input ready);
    modport sink   (input valid, candidate_score, random_fraction, output ready);
endinterface

interface aau_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        by_chance;
    logic        new_best;
    logic        finished;
    logic [47:0] best_score;
    logic [47:0] current_score_out;
    logic [31:0] temperature_out;
    logic [31:0] step_count;

    modport source (output valid, accepted, by_chance, new_best, finished, best_score,
                    current_score_out, temperature_out, step_count, input ready);
    modport sink   (input valid, accepted, by_chance, new_best, finished, best_score,
                    current_score_out, temperature_out, step_count, output ready);
endinterface

interface aau_cfg_if;
    logic                valid;
    logic                ready;
    aau_pkg::t_cfg_idx   index;
    logic [31:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/aau_datapath.sv -----
// ----------------------------------------------------------------------------
// aau_datapath: registers and arithmetic of the acceptance unit
// Holds the annealing state, the configuration registers, the iterative
// dividers, the Taylor multiplier and the result register.
// ----------------------------------------------------------------------------
module aau_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aau_pkg::t_dp_cmd     i_cmd,
    output aau_pkg::t_dp_status  o_status,
    input  logic [47:0]          i_candidate_score,
    input  logic [15:0]          i_random_fraction,
    input  logic                 i_cfg_we,
    input  aau_pkg::t_cfg_idx    i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_accepted,
    output logic                 o_by_chance,
    output logic                 o_new_best,
    output logic                 o_finished,
    output logic [47:0]          o_best_score,
    output logic [47:0]          o_current_score_out,
    output logic [31:0]          o_temperature_out,
    output logic [31:0]          o_step_count
);
    import aau_pkg::*;

    logic [31:0] r_start, r_cool, r_stop;
    logic        r_seeded, r_stopped;
    logic [47:0] r_cur, r_best;
    logic [31:0] r_temp, r_iter, r_impr, r_uphill;

    logic [47:0] r_score;
    logic [15:0] r_rnd;
    logic [47:0] r_diff;
    logic        r_lt, r_le;
    logic [35:0] r_den;
    logic [31:0] r_cooled;
    logic [36:0] r_rem;
    logic [19:0] r_q;
    logic [35:0] r_x;
    logic [4:0]  r_n;
    logic [32:0] r_term;
    logic [33:0] r_pos, r_neg;
    logic [3:0]  r_k;
    logic [35:0] r_dvd;
    logic [3:0]  r_krem;
    logic [16:0] r_p;
    logic        r_acc, r_chance, r_nb;

    logic [63:0] cool_prod;
    logic [64:0] taylor_prod;
    logic [36:0] q_rem2, q_rem_nxt;
    logic        q_bit;
    logic [36:0] ln2_sh;
    logic        n_bit;
    logic [35:0] kdiv_dvd_nxt;
    logic [3:0]  kdiv_rem_nxt;
    logic [33:0] e_val;
    logic [5:0]  rnd_sh;
    logic [39:0] rnd_sum;
    logic        chance_ok;

    assign cool_prod   = 64'(r_temp) * 64'(r_cool);
    assign taylor_prod = 65'(r_term) * 65'(r_x[31:0]);

    assign q_rem2    = {r_rem[35:0], 1'b0};
    assign q_bit     = q_rem2 >= {1'b0, r_den};
    assign q_rem_nxt = q_bit ? (q_rem2 - {1'b0, r_den}) : q_rem2;

    assign ln2_sh = 37'(LN2_Q32) << i_cmd.cnt[2:0];
    assign n_bit  = {1'b0, r_x} >= ln2_sh;

    // Four quotient bits per cycle of the division by the term index.
    always_comb begin
        logic [4:0]  rem5;
        logic [3:0]  rem4;
        logic [35:0] dvd;
        rem4 = r_krem;
        dvd  = r_dvd;
        for (int j = 0; j < 4; j++) begin
            rem5 = {rem4, dvd[35]};
            dvd  = {dvd[34:0], 1'b0};
            if (rem5 >= {1'b0, r_k}) begin
                rem5   = rem5 - {1'b0, r_k};
                dvd[0] = 1'b1;
            end
            rem4 = rem5[3:0];
        end
        kdiv_dvd_nxt = dvd;
        kdiv_rem_nxt = rem4;
    end

    assign e_val   = r_pos - r_neg;
    assign rnd_sh  = 6'd16 + 6'(r_n);
    assign rnd_sum = 40'(e_val) + (40'd1 << (rnd_sh - 6'd1));
    assign chance_ok = {1'b0, r_rnd} < r_p;

    assign o_status.seeded    = r_seeded;
    assign o_status.stopped   = r_stopped;
    assign o_status.lt_cur    = r_lt;
    assign o_status.diff_zero = (r_diff == '0);
    assign o_status.big       = (r_diff[47:24] != '0) || ({r_diff[23:0], 12'b0} >= r_den);
    assign o_status.k_last    = (r_k == TAYLOR_TERMS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_TEMP_RST;
            r_cool  <= COOL_RST;
            r_stop  <= STOP_TEMP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_TEMP: r_start <= i_cfg_data;
                CFG_COOLING:    r_cool  <= i_cfg_data;
                CFG_STOP_TEMP:  r_stop  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Annealing state, updated once per decided item until the unit has stopped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded  <= 1'b0;
            r_stopped <= 1'b0;
            r_cur     <= '1;
            r_best    <= '1;
            r_temp    <= START_TEMP_RST;
            r_iter    <= '0;
            r_impr    <= '0;
            r_uphill  <= '0;
        end else if (i_cmd.op == OP_COMMIT && !r_stopped) begin
            if (!r_seeded) begin
                r_seeded <= 1'b1;
                r_cur    <= r_score;
                r_best   <= r_score;
                r_temp   <= r_start;
            end else begin
                if (r_le) begin
                    r_best <= r_score;
                end
                if (r_lt) begin
                    r_cur <= r_score;
                    if (r_impr != '1) r_impr <= r_impr + 32'd1;
                end else if (chance_ok) begin
                    r_cur <= r_score;
                    if (r_uphill != '1) r_uphill <= r_uphill + 32'd1;
                end
                if (r_iter != '1) r_iter <= r_iter + 32'd1;
                if (r_temp < r_stop) begin
                    r_stopped <= 1'b1;
                end else begin
                    r_temp <= r_cooled;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_score <= i_candidate_score;
                r_rnd   <= i_random_fraction;
            end
            OP_CHECK: begin
                r_diff   <= r_score - r_cur;
                r_lt     <= r_score < r_cur;
                r_le     <= r_score <= r_best;
                r_den    <= 36'({r_temp, 3'b000}) + 36'({r_temp, 1'b0});
                r_cooled <= cool_prod[63:32];
            end
            OP_EVAL: begin
                r_p   <= (r_diff == '0) ? ONE_Q16 : 17'd0;
                r_rem <= {1'b0, r_diff[23:0], 12'b0};
                r_q   <= '0;
            end
            OP_QSTEP: begin
                r_rem <= q_rem_nxt;
                r_q   <= {r_q[18:0], q_bit};
                r_x   <= {r_q[18:0], q_bit, 16'b0};
                r_n   <= '0;
            end
            OP_NSTEP: begin
                if (n_bit) r_x <= 36'({1'b0, r_x} - ln2_sh);
                r_n    <= {r_n[3:0], n_bit};
                r_term <= 33'h1_0000_0000;
                r_pos  <= 34'h1_0000_0000;
                r_neg  <= '0;
                r_k    <= 4'd1;
            end
            OP_MUL: begin
                r_dvd  <= {3'b000, taylor_prod[64:32]};
                r_krem <= '0;
            end
            OP_KDIV: begin
                r_dvd  <= kdiv_dvd_nxt;
                r_krem <= kdiv_rem_nxt;
            end
            OP_ACC: begin
                r_term <= r_dvd[32:0];
                if (r_k[0]) begin
                    r_neg <= r_neg + 34'(r_dvd[32:0]);
                end else begin
                    r_pos <= r_pos + 34'(r_dvd[32:0]);
                end
                r_k <= r_k + 4'd1;
            end
            OP_ROUND: begin
                r_p <= 17'(rnd_sum >> rnd_sh);
            end
            OP_COMMIT: begin
                r_acc    <= !r_stopped && (!r_seeded || r_lt || chance_ok);
                r_chance <= !r_stopped && r_seeded && !r_lt && chance_ok;
                r_nb     <= !r_stopped && (!r_seeded || r_le);
            end
            OP_OUT: begin
                o_accepted          <= r_acc;
                o_by_chance         <= r_chance;
                o_new_best          <= r_nb;
                o_finished          <= r_stopped;
                o_best_score        <= r_best;
                o_current_score_out <= r_cur;
                o_temperature_out   <= r_temp;
                o_step_count        <= r_iter;
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/aau_controller.sv -----
// ----------------------------------------------------------------------------
// aau_controller: sequencer of the acceptance unit
// Steps the datapath through classification, the quotient and range
// reduction, the Taylor series and the commit, and owns the result valid.
// ----------------------------------------------------------------------------
module aau_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  aau_pkg::t_dp_status  i_status,
    output aau_pkg::t_dp_cmd     o_cmd
);
    import aau_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NONE;
        o_cmd.cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.op = OP_EVAL;
                if (i_status.stopped || !i_status.seeded || i_status.lt_cur ||
                    i_status.diff_zero || i_status.big) begin
                    n_state = S_COMMIT;
                end else begin
                    n_state = S_QDIV;
                    n_cnt   = QDIV_LAST;
                end
            end
            S_QDIV: begin
                o_cmd.op = OP_QSTEP;
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_NDIV;
                    n_cnt   = NDIV_LAST;
                end
            end
            S_NDIV: begin
                o_cmd.op = OP_NSTEP;
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_KDIV;
                n_cnt    = KDIV_LAST;
            end
            S_KDIV: begin
                o_cmd.op = OP_KDIV;
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = i_status.k_last ? S_ROUND : S_MUL;
            end
            S_ROUND: begin
                o_cmd.op = OP_ROUND;
                n_state  = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.op = OP_COMMIT;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_load_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_CHECK))
        else $error("accepted item did not start classification");

    a_qdiv_to_ndiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QDIV && r_cnt == '0) |=> (r_state == S_NDIV && r_cnt == NDIV_LAST))
        else $error("quotient division did not hand over to range reduction");

    a_out_loads_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result load did not raise valid");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_IDLE && !r_out_valid))
        else $error("reset did not clear the controller");

endmodule

// ----- rtl/annealing_acceptance_unit.sv -----
// ----------------------------------------------------------------------------
// annealing_acceptance_unit: Metropolis acceptance for simulated annealing
// Decides per candidate score whether it replaces the current solution,
// tracks the best score and cools the temperature until it stops.
// ----------------------------------------------------------------------------
// The block takes one request at a time on i_item and returns one result on
// o_result for every request. The first request after reset seeds the current
// and best scores and loads the temperature from start_temperature; it and any
// request after the block has finished go from acceptance through the check,
// evaluate, commit and output steps to their result, and the next request can
// be taken once the output step has loaded that result. A candidate that
// improves on the current score, equals it, or lies so far above it that the
// acceptance probability is zero takes the same path to its result. Any other
// worse candidate runs the exponential: a shift-subtract division of the score
// rise by ten times the temperature, a reduction by ln(2), and 12 Taylor terms
// (one multiply step, a division by the term index at four bits a cycle, one
// accumulate step), followed by one rounding step and the commit and output
// steps. A stalled o_result holds only the next request, in its output step,
// until the stalled result is taken. A new request is taken as soon as the
// result is in the output register, even while that result still waits for
// o_result.ready. Configuration writes on i_cfg are always ready and must be
// made while the block is idle.
// ----------------------------------------------------------------------------
module annealing_acceptance_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aau_item_if.sink     i_item,
    aau_result_if.source o_result,
    aau_cfg_if.sink      i_cfg
);
    import aau_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign i_cfg.ready = 1'b1;

    aau_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    aau_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_status            (dp_status),
        .i_candidate_score   (i_item.candidate_score),
        .i_random_fraction   (i_item.random_fraction),
        .i_cfg_we            (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .o_accepted          (o_result.accepted),
        .o_by_chance         (o_result.by_chance),
        .o_new_best          (o_result.new_best),
        .o_finished          (o_result.finished),
        .o_best_score        (o_result.best_score),
        .o_current_score_out (o_result.current_score_out),
        .o_temperature_out   (o_result.temperature_out),
        .o_step_count        (o_result.step_count)
    );

endmodule
